// ----- rtl/lav_pkg.sv -----
// shared constants for the look-at view matrix pipeline
package lav_pkg;

  localparam int DATA_W        = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int VEC_N         = 3;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] TOP_ONE = 32'h8000_0000;
  localparam logic [DATA_W-1:0] TOP_ONE_P1 = 32'h8000_0001;

endpackage

// ----- rtl/look_at_view_matrix.sv -----
// look-at view matrix top level: input stage, two normalizers, cross and dot products
// One camera setup is taken in every cycle (busy stays low) and its three matrix rows
// come out on a one-cycle out_valid strobe, in Q16.16 at the default FRAC_BITS;
// the receiver cannot stall. Each of the two normalizers holds a 32-stage square root
// followed by a FRAC_BITS+1 stage divider.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_look_x,
  input  logic signed [31:0] in_look_y,
  input  logic signed [31:0] in_look_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic        out_valid,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m03,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m13,
  output logic signed [31:0] out_m20,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22,
  output logic signed [31:0] out_m23
);

  localparam int DW   = lav_pkg::DATA_W;
  localparam int VN   = lav_pkg::VEC_N;
  localparam int ZW   = DW + 1;
  localparam int NOW  = FRAC_BITS + 2;
  localparam int XPW  = DW + NOW;
  localparam int XBW  = XPW + 1;
  localparam int PAYA = 2 * VN * DW;
  localparam int PAYB = VN * (DW + NOW);
  localparam int YPW  = 2 * NOW;
  localparam int YCW  = YPW + 1;
  localparam int YW   = FRAC_BITS + 4;
  localparam int DPW  = YW + DW;
  localparam int DSW  = DPW + 2;

  assign busy = 1'b0;

  // input stage
  logic                 s0_valid_r;
  logic signed [DW-1:0] s0_eye_r [VN];
  logic signed [DW-1:0] s0_up_r [VN];
  logic signed [ZW-1:0] s0_zb_r [VN];

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else s0_valid_r <= start;
  end

  always_ff @(posedge clk) begin
    s0_eye_r[0] <= in_eye_x;
    s0_eye_r[1] <= in_eye_y;
    s0_eye_r[2] <= in_eye_z;
    s0_up_r[0]  <= in_up_x;
    s0_up_r[1]  <= in_up_y;
    s0_up_r[2]  <= in_up_z;
    s0_zb_r[0]  <= -ZW'(in_look_x);
    s0_zb_r[1]  <= -ZW'(in_look_y);
    s0_zb_r[2]  <= -ZW'(in_look_z);
  end

  // back axis
  logic                  a_valid;
  logic signed [NOW-1:0] a_zn [VN];
  logic [PAYA-1:0]       a_pay;
  logic signed [DW-1:0]  a_eye [VN];
  logic signed [DW-1:0]  a_up [VN];

  lav_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (ZW),
    .PAY_W     (PAYA)
  ) u_norm_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_vec    (s0_zb_r),
    .in_pay    ({s0_up_r[2], s0_up_r[1], s0_up_r[0], s0_eye_r[2], s0_eye_r[1], s0_eye_r[0]}),
    .out_valid (a_valid),
    .out_vec   (a_zn),
    .out_pay   (a_pay)
  );

  always_comb begin
    for (int i = 0; i < VN; i++) begin
      a_eye[i] = $signed(a_pay[i*DW +: DW]);
      a_up[i]  = $signed(a_pay[(VN+i)*DW +: DW]);
    end
  end

  // up cross z: partial products, then differences
  logic                  x1_valid_r;
  logic signed [XPW-1:0] x1_p_r [2*VN];
  logic signed [DW-1:0]  x1_eye_r [VN];
  logic signed [NOW-1:0] x1_zn_r [VN];

  always_ff @(posedge clk) begin
    if (!rst_n) x1_valid_r <= 1'b0;
    else x1_valid_r <= a_valid;
  end

  always_ff @(posedge clk) begin
    x1_p_r[0] <= XPW'(a_up[1]) * XPW'(a_zn[2]);
    x1_p_r[1] <= XPW'(a_up[2]) * XPW'(a_zn[1]);
    x1_p_r[2] <= XPW'(a_up[2]) * XPW'(a_zn[0]);
    x1_p_r[3] <= XPW'(a_up[0]) * XPW'(a_zn[2]);
    x1_p_r[4] <= XPW'(a_up[0]) * XPW'(a_zn[1]);
    x1_p_r[5] <= XPW'(a_up[1]) * XPW'(a_zn[0]);
    x1_eye_r  <= a_eye;
    x1_zn_r   <= a_zn;
  end

  logic                  x2_valid_r;
  logic signed [XBW-1:0] x2_b_r [VN];
  logic signed [DW-1:0]  x2_eye_r [VN];
  logic signed [NOW-1:0] x2_zn_r [VN];

  always_ff @(posedge clk) begin
    if (!rst_n) x2_valid_r <= 1'b0;
    else x2_valid_r <= x1_valid_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      x2_b_r[i] <= XBW'(x1_p_r[2*i]) - XBW'(x1_p_r[2*i+1]);
    end
    x2_eye_r <= x1_eye_r;
    x2_zn_r  <= x1_zn_r;
  end

  // right axis
  logic                  b_valid;
  logic signed [NOW-1:0] b_xn [VN];
  logic [PAYB-1:0]       b_pay;
  logic signed [DW-1:0]  b_eye [VN];
  logic signed [NOW-1:0] b_zn [VN];

  lav_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (XBW),
    .PAY_W     (PAYB)
  ) u_norm_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (x2_valid_r),
    .in_vec    (x2_b_r),
    .in_pay    ({x2_zn_r[2], x2_zn_r[1], x2_zn_r[0], x2_eye_r[2], x2_eye_r[1], x2_eye_r[0]}),
    .out_valid (b_valid),
    .out_vec   (b_xn),
    .out_pay   (b_pay)
  );

  always_comb begin
    for (int i = 0; i < VN; i++) begin
      b_eye[i] = $signed(b_pay[i*DW +: DW]);
      b_zn[i]  = $signed(b_pay[VN*DW + i*NOW +: NOW]);
    end
  end

  // z cross x at double precision
  logic                  y1_valid_r;
  logic signed [YPW-1:0] y1_p_r [2*VN];
  logic signed [DW-1:0]  y1_eye_r [VN];
  logic signed [NOW-1:0] y1_zn_r [VN];
  logic signed [NOW-1:0] y1_xn_r [VN];

  always_ff @(posedge clk) begin
    if (!rst_n) y1_valid_r <= 1'b0;
    else y1_valid_r <= b_valid;
  end

  always_ff @(posedge clk) begin
    y1_p_r[0] <= YPW'(b_zn[1]) * YPW'(b_xn[2]);
    y1_p_r[1] <= YPW'(b_zn[2]) * YPW'(b_xn[1]);
    y1_p_r[2] <= YPW'(b_zn[2]) * YPW'(b_xn[0]);
    y1_p_r[3] <= YPW'(b_zn[0]) * YPW'(b_xn[2]);
    y1_p_r[4] <= YPW'(b_zn[0]) * YPW'(b_xn[1]);
    y1_p_r[5] <= YPW'(b_zn[1]) * YPW'(b_xn[0]);
    y1_eye_r  <= b_eye;
    y1_zn_r   <= b_zn;
    y1_xn_r   <= b_xn;
  end

  logic                  y2_valid_r;
  logic signed [YCW-1:0] y2_c_r [VN];
  logic signed [DW-1:0]  y2_eye_r [VN];
  logic signed [NOW-1:0] y2_zn_r [VN];
  logic signed [NOW-1:0] y2_xn_r [VN];

  always_ff @(posedge clk) begin
    if (!rst_n) y2_valid_r <= 1'b0;
    else y2_valid_r <= y1_valid_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      y2_c_r[i] <= YCW'(y1_p_r[2*i]) - YCW'(y1_p_r[2*i+1]);
    end
    y2_eye_r <= y1_eye_r;
    y2_zn_r  <= y1_zn_r;
    y2_xn_r  <= y1_xn_r;
  end

  // round the up axis to nearest, ties away from zero
  logic                  y3_valid_r;
  logic signed [YW-1:0]  y3_yn_r [VN];
  logic signed [YW-1:0]  y3_yn_nxt [VN];
  logic signed [DW-1:0]  y3_eye_r [VN];
  logic signed [NOW-1:0] y3_zn_r [VN];
  logic signed [NOW-1:0] y3_xn_r [VN];

  always_comb begin
    logic [YCW:0] ymag [VN];
    logic [YCW:0] yq [VN];
    for (int i = 0; i < VN; i++) begin
      ymag[i] = {1'b0, y2_c_r[i][YCW-1] ? YCW'(-y2_c_r[i]) : YCW'(y2_c_r[i])};
      yq[i]   = (ymag[i] + ((YCW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (y2_c_r[i][YCW-1]) y3_yn_nxt[i] = -$signed(YW'(yq[i]));
      else y3_yn_nxt[i] = $signed(YW'(yq[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) y3_valid_r <= 1'b0;
    else y3_valid_r <= y2_valid_r;
  end

  always_ff @(posedge clk) begin
    y3_yn_r  <= y3_yn_nxt;
    y3_eye_r <= y2_eye_r;
    y3_zn_r  <= y2_zn_r;
    y3_xn_r  <= y2_xn_r;
  end

  // translation: axis dot eye per row
  logic                  d1_valid_r;
  logic signed [DPW-1:0] d1_p_r [VN][VN];
  logic signed [YW-1:0]  d1_ax_r [VN][VN];
  logic signed [YW-1:0]  d1_ax_nxt [VN][VN];

  always_comb begin
    for (int c = 0; c < VN; c++) begin
      d1_ax_nxt[0][c] = YW'(y3_xn_r[c]);
      d1_ax_nxt[1][c] = y3_yn_r[c];
      d1_ax_nxt[2][c] = YW'(y3_zn_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d1_valid_r <= 1'b0;
    else d1_valid_r <= y3_valid_r;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < VN; r++) begin
      for (int c = 0; c < VN; c++) begin
        d1_p_r[r][c] <= DPW'(d1_ax_nxt[r][c]) * DPW'(y3_eye_r[c]);
      end
    end
    d1_ax_r <= d1_ax_nxt;
  end

  logic                  d2_valid_r;
  logic signed [DSW-1:0] d2_s_r [VN];
  logic signed [YW-1:0]  d2_ax_r [VN][VN];

  always_ff @(posedge clk) begin
    if (!rst_n) d2_valid_r <= 1'b0;
    else d2_valid_r <= d1_valid_r;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < VN; r++) begin
      d2_s_r[r] <= DSW'(d1_p_r[r][0]) + DSW'(d1_p_r[r][1]) + DSW'(d1_p_r[r][2]);
    end
    d2_ax_r <= d1_ax_r;
  end

  // round, negate and clamp to 32 bits
  logic                 d3_valid_r;
  logic signed [DW-1:0] d3_t_r [VN];
  logic signed [DW-1:0] d3_t_nxt [VN];
  logic signed [YW-1:0] d3_ax_r [VN][VN];

  always_comb begin
    logic [DSW:0] dmag [VN];
    logic [DSW:0] dq [VN];
    for (int r = 0; r < VN; r++) begin
      dmag[r] = {1'b0, d2_s_r[r][DSW-1] ? DSW'(-d2_s_r[r]) : DSW'(d2_s_r[r])};
      dq[r]   = (dmag[r] + ((DSW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (d2_s_r[r][DSW-1]) begin
        if (dq[r] > (DSW+1)'(lav_pkg::S32_MAX)) d3_t_nxt[r] = lav_pkg::S32_MAX;
        else d3_t_nxt[r] = DW'(dq[r]);
      end else begin
        if (dq[r] > (DSW+1)'(lav_pkg::S32_MIN)) d3_t_nxt[r] = lav_pkg::S32_MIN;
        else d3_t_nxt[r] = DW'(-dq[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d3_valid_r <= 1'b0;
    else d3_valid_r <= d2_valid_r;
  end

  always_ff @(posedge clk) begin
    d3_t_r  <= d3_t_nxt;
    d3_ax_r <= d2_ax_r;
  end

  assign out_valid = d3_valid_r;
  assign out_m00 = DW'(d3_ax_r[0][0]);
  assign out_m01 = DW'(d3_ax_r[0][1]);
  assign out_m02 = DW'(d3_ax_r[0][2]);
  assign out_m03 = d3_t_r[0];
  assign out_m10 = DW'(d3_ax_r[1][0]);
  assign out_m11 = DW'(d3_ax_r[1][1]);
  assign out_m12 = DW'(d3_ax_r[1][2]);
  assign out_m13 = d3_t_r[1];
  assign out_m20 = DW'(d3_ax_r[2][0]);
  assign out_m21 = DW'(d3_ax_r[2][1]);
  assign out_m22 = DW'(d3_ax_r[2][2]);
  assign out_m23 = d3_t_r[2];

endmodule

// ----- rtl/lav_norm.sv -----
// pipelined vector normalizer: align, squares, bit-serial sqrt stages, divider stages
module lav_norm #(
  parameter int FRAC_BITS = lav_pkg::DEF_FRAC_BITS,
  parameter int IN_W      = lav_pkg::DATA_W + 1,
  parameter int PAY_W     = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [IN_W-1:0]   in_vec [lav_pkg::VEC_N],
  input  logic [PAY_W-1:0]         in_pay,
  output logic                     out_valid,
  output logic signed [FRAC_BITS+1:0] out_vec [lav_pkg::VEC_N],
  output logic [PAY_W-1:0]         out_pay
);

  localparam int VN  = lav_pkg::VEC_N;
  localparam int MW  = lav_pkg::DATA_W;
  localparam int LW  = IN_W + MW;
  localparam int PBW = $clog2(IN_W);
  localparam int SQW = 2 * MW;
  localparam int RW  = MW + 4;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NUW = FRAC_BITS + MW + 1;
  localparam int OW  = FRAC_BITS + 2;

  // stage 1: magnitudes and largest magnitude
  logic              n1_valid_r;
  logic [IN_W-1:0]   n1_mag_r [VN];
  logic [IN_W-1:0]   n1_mag_nxt [VN];
  logic [IN_W-1:0]   n1_top_r, n1_top_nxt;
  logic [VN-1:0]     n1_sign_r;
  logic [PAY_W-1:0]  n1_pay_r;

  always_comb begin
    for (int i = 0; i < VN; i++) begin
      n1_mag_nxt[i] = in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
    end
    n1_top_nxt = n1_mag_nxt[0];
    if (n1_mag_nxt[1] > n1_top_nxt) n1_top_nxt = n1_mag_nxt[1];
    if (n1_mag_nxt[2] > n1_top_nxt) n1_top_nxt = n1_mag_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n1_valid_r <= 1'b0;
    else n1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      n1_mag_r[i]  <= n1_mag_nxt[i];
      n1_sign_r[i] <= in_vec[i][IN_W-1];
    end
    n1_top_r <= n1_top_nxt;
    n1_pay_r <= in_pay;
  end

  // stage 2: leading one of the largest magnitude
  logic              n2_valid_r;
  logic [IN_W-1:0]   n2_mag_r [VN];
  logic [IN_W-1:0]   n2_top_r;
  logic [PBW-1:0]    n2_sh_r, n2_sh_nxt;
  logic              n2_zero_r;
  logic [VN-1:0]     n2_sign_r;
  logic [PAY_W-1:0]  n2_pay_r;

  always_comb begin
    logic [PBW-1:0] pos;
    pos = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (n1_top_r[b]) pos = PBW'(b);
    end
    n2_sh_nxt = PBW'(IN_W - 1) - pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n2_valid_r <= 1'b0;
    else n2_valid_r <= n1_valid_r;
  end

  always_ff @(posedge clk) begin
    n2_mag_r  <= n1_mag_r;
    n2_top_r  <= n1_top_r;
    n2_sh_r   <= n2_sh_nxt;
    n2_zero_r <= (n1_top_r == '0);
    n2_sign_r <= n1_sign_r;
    n2_pay_r  <= n1_pay_r;
  end

  // stage 3: left-align all components by the same amount
  logic              n3_valid_r;
  logic [LW-1:0]     n3_al_r [VN];
  logic [MW-1:0]     n3_a_r;
  logic [LW-1:0]     n3_tal_nxt;
  logic              n3_zero_r;
  logic [VN-1:0]     n3_sign_r;
  logic [PAY_W-1:0]  n3_pay_r;

  assign n3_tal_nxt = {n2_top_r, MW'(0)} << n2_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n3_valid_r <= 1'b0;
    else n3_valid_r <= n2_valid_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      n3_al_r[i] <= {n2_mag_r[i], MW'(0)} << n2_sh_r;
    end
    n3_a_r    <= n3_tal_nxt[LW-1 -: MW];
    n3_zero_r <= n2_zero_r;
    n3_sign_r <= n2_sign_r;
    n3_pay_r  <= n2_pay_r;
  end

  // stage 4: pick the 32-bit window so the largest lands in (2^30, 2^31]
  // a largest of exactly 2^31+1 before the window loses its low bit
  logic              n4_valid_r;
  logic [MW-1:0]     n4_m_r [VN];
  logic [MW-1:0]     n4_m_nxt [VN];
  logic              n4_zero_r;
  logic [VN-1:0]     n4_sign_r;
  logic [PAY_W-1:0]  n4_pay_r;

  always_comb begin
    for (int i = 0; i < VN; i++) begin
      if (n3_a_r == lav_pkg::TOP_ONE) n4_m_nxt[i] = n3_al_r[i][LW-1 -: MW];
      else if (n3_a_r == lav_pkg::TOP_ONE_P1) n4_m_nxt[i] = {n3_al_r[i][LW-1 -: MW-1], 1'b0};
      else n4_m_nxt[i] = {1'b0, n3_al_r[i][LW-1 -: MW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n4_valid_r <= 1'b0;
    else n4_valid_r <= n3_valid_r;
  end

  always_ff @(posedge clk) begin
    n4_m_r    <= n4_m_nxt;
    n4_zero_r <= n3_zero_r;
    n4_sign_r <= n3_sign_r;
    n4_pay_r  <= n3_pay_r;
  end

  // stage 5: squares
  logic              n5_valid_r;
  logic [SQW-1:0]    n5_sq_r [VN];
  logic [MW-1:0]     n5_m_r [VN];
  logic              n5_zero_r;
  logic [VN-1:0]     n5_sign_r;
  logic [PAY_W-1:0]  n5_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n5_valid_r <= 1'b0;
    else n5_valid_r <= n4_valid_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      n5_sq_r[i] <= SQW'(n4_m_r[i]) * SQW'(n4_m_r[i]);
    end
    n5_m_r    <= n4_m_r;
    n5_zero_r <= n4_zero_r;
    n5_sign_r <= n4_sign_r;
    n5_pay_r  <= n4_pay_r;
  end

  // square root, one root bit per stage; index 0 holds the sum of squares
  logic              sr_valid_r [MW+1];
  logic [SQW-1:0]    sr_rad_r [MW+1];
  logic [RW-1:0]     sr_rem_r [MW+1];
  logic [MW-1:0]     sr_root_r [MW+1];
  logic [MW-1:0]     sr_m_r [MW+1][VN];
  logic              sr_zero_r [MW+1];
  logic [VN-1:0]     sr_sign_r [MW+1];
  logic [PAY_W-1:0]  sr_pay_r [MW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sr_valid_r[0] <= 1'b0;
    else sr_valid_r[0] <= n5_valid_r;
  end

  always_ff @(posedge clk) begin
    sr_rad_r[0]  <= n5_sq_r[0] + n5_sq_r[1] + n5_sq_r[2];
    sr_rem_r[0]  <= '0;
    sr_root_r[0] <= '0;
    sr_m_r[0]    <= n5_m_r;
    sr_zero_r[0] <= n5_zero_r;
    sr_sign_r[0] <= n5_sign_r;
    sr_pay_r[0]  <= n5_pay_r;
  end

  for (genvar k = 1; k <= MW; k++) begin : g_sqrt
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    assign rem_sh = {sr_rem_r[k-1][RW-3:0], sr_rad_r[k-1][SQW-1 -: 2]};
    assign trial  = RW'({sr_root_r[k-1], 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) sr_valid_r[k] <= 1'b0;
      else sr_valid_r[k] <= sr_valid_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (rem_sh >= trial) begin
        sr_rem_r[k]  <= rem_sh - trial;
        sr_root_r[k] <= {sr_root_r[k-1][MW-2:0], 1'b1};
      end else begin
        sr_rem_r[k]  <= rem_sh;
        sr_root_r[k] <= {sr_root_r[k-1][MW-2:0], 1'b0};
      end
      sr_rad_r[k]  <= sr_rad_r[k-1] << 2;
      sr_m_r[k]    <= sr_m_r[k-1];
      sr_zero_r[k] <= sr_zero_r[k-1];
      sr_sign_r[k] <= sr_sign_r[k-1];
      sr_pay_r[k]  <= sr_pay_r[k-1];
    end
  end

  // divider: index 0 holds the rounded numerators, then one quotient bit per stage
  logic              dv_valid_r [QW+1];
  logic [NUW-1:0]    dv_rem_r [QW+1][VN];
  logic [QW-1:0]     dv_q_r [QW+1][VN];
  logic [MW-1:0]     dv_den_r [QW+1];
  logic              dv_zero_r [QW+1];
  logic [VN-1:0]     dv_sign_r [QW+1];
  logic [PAY_W-1:0]  dv_pay_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_valid_r[0] <= 1'b0;
    else dv_valid_r[0] <= sr_valid_r[MW];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      dv_rem_r[0][i] <= NUW'({sr_m_r[MW][i], FRAC_BITS'(0)}) + NUW'(sr_root_r[MW] >> 1);
      dv_q_r[0][i]   <= '0;
    end
    dv_den_r[0]  <= sr_root_r[MW];
    dv_zero_r[0] <= sr_zero_r[MW];
    dv_sign_r[0] <= sr_sign_r[MW];
    dv_pay_r[0]  <= sr_pay_r[MW];
  end

  for (genvar t = 1; t <= QW; t++) begin : g_div
    logic [NUW-1:0] dsub;

    assign dsub = NUW'(dv_den_r[t-1]) << (QW - t);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_valid_r[t] <= 1'b0;
      else dv_valid_r[t] <= dv_valid_r[t-1];
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < VN; i++) begin
        if (dv_rem_r[t-1][i] >= dsub) begin
          dv_rem_r[t][i] <= dv_rem_r[t-1][i] - dsub;
          dv_q_r[t][i]   <= {dv_q_r[t-1][i][QW-2:0], 1'b1};
        end else begin
          dv_rem_r[t][i] <= dv_rem_r[t-1][i];
          dv_q_r[t][i]   <= {dv_q_r[t-1][i][QW-2:0], 1'b0};
        end
      end
      dv_den_r[t]  <= dv_den_r[t-1];
      dv_zero_r[t] <= dv_zero_r[t-1];
      dv_sign_r[t] <= dv_sign_r[t-1];
      dv_pay_r[t]  <= dv_pay_r[t-1];
    end
  end

  // output: sign back on, zero-length vector gives zero
  logic                 ot_valid_r;
  logic signed [OW-1:0] ot_vec_r [VN];
  logic [PAY_W-1:0]     ot_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ot_valid_r <= 1'b0;
    else ot_valid_r <= dv_valid_r[QW];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VN; i++) begin
      if (dv_zero_r[QW]) ot_vec_r[i] <= '0;
      else if (dv_sign_r[QW][i]) ot_vec_r[i] <= -$signed(OW'(dv_q_r[QW][i]));
      else ot_vec_r[i] <= $signed(OW'(dv_q_r[QW][i]));
    end
    ot_pay_r <= dv_pay_r[QW];
  end

  assign out_valid = ot_valid_r;
  assign out_vec   = ot_vec_r;
  assign out_pay   = ot_pay_r;

endmodule

// ----- tb/look_at_view_matrix_tb.sv -----
// testbench for the look-at view matrix: directed and random camera setups checked per beat
module look_at_view_matrix_tb;

  localparam int FB = lav_pkg::DEF_FRAC_BITS;
  localparam int LATENCY = 2 * FB + 91;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] look [3];
    logic signed [31:0] up [3];
  } camera_t;

  typedef struct {
    logic signed [31:0] m [12];
  } view_rows_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [31:0] in_look_x = '0, in_look_y = '0, in_look_z = '0;
  logic signed [31:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic signed [31:0] out_m00, out_m01, out_m02, out_m03;
  logic signed [31:0] out_m10, out_m11, out_m12, out_m13;
  logic signed [31:0] out_m20, out_m21, out_m22, out_m23;

  view_rows_t expected_rows [$];
  int n_errors = 0;
  longint cycle_count = 0;

  look_at_view_matrix #(.FRAC_BITS(FB)) dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_frac(longint v);
    longint unsigned q;
    q = (magnitude(v) + (64'd1 << (FB - 1))) >> FB;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void unit_vector(input longint v [3], output longint u [3]);
    longint unsigned m [3];
    longint unsigned peak = 0, sumsq, len, q;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(v[i]);
      if (m[i] > peak) peak = m[i];
    end
    if (peak == 0) begin
      foreach (u[i]) u[i] = 0;
      return;
    end
    while (peak > (64'd1 << 31)) begin
      foreach (m[i]) m[i] >>= 1;
      peak >>= 1;
    end
    while (peak <= (64'd1 << 30)) begin
      foreach (m[i]) m[i] <<= 1;
      peak <<= 1;
    end
    sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic logic signed [31:0] neg_dot_clamped(longint a [3], longint e [3]);
    longint t;
    t = -round_frac(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    if (t > longint'(signed'(lav_pkg::S32_MAX))) return lav_pkg::S32_MAX;
    if (t < longint'(signed'(lav_pkg::S32_MIN))) return lav_pkg::S32_MIN;
    return t[31:0];
  endfunction

  function automatic view_rows_t compute_view(camera_t c);
    view_rows_t r;
    longint eye [3], back_raw [3], right_raw [3], bk [3], rt [3], upv [3];
    for (int i = 0; i < 3; i++) begin
      eye[i] = c.eye[i];
      back_raw[i] = -longint'(c.look[i]);
    end
    unit_vector(back_raw, bk);
    right_raw[0] = c.up[1] * bk[2] - c.up[2] * bk[1];
    right_raw[1] = c.up[2] * bk[0] - c.up[0] * bk[2];
    right_raw[2] = c.up[0] * bk[1] - c.up[1] * bk[0];
    unit_vector(right_raw, rt);
    upv[0] = round_frac(bk[1] * rt[2] - bk[2] * rt[1]);
    upv[1] = round_frac(bk[2] * rt[0] - bk[0] * rt[2]);
    upv[2] = round_frac(bk[0] * rt[1] - bk[1] * rt[0]);
    for (int i = 0; i < 3; i++) begin
      r.m[i] = rt[i][31:0];
      r.m[4 + i] = upv[i][31:0];
      r.m[8 + i] = bk[i][31:0];
    end
    r.m[3] = neg_dot_clamped(rt, eye);
    r.m[7] = neg_dot_clamped(upv, eye);
    r.m[11] = neg_dot_clamped(bk, eye);
    return r;
  endfunction

  // result checker: the receiver cannot stall, so every strobe is a beat
  always @(posedge clk) begin
    view_rows_t want;
    logic signed [31:0] got [12];
    if (rst_n && out_valid) begin
      got = '{out_m00, out_m01, out_m02, out_m03, out_m10, out_m11, out_m12, out_m13,
              out_m20, out_m21, out_m22, out_m23};
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result beat, actual m00=%h", $time, out_m00);
        n_errors++;
      end else begin
        want = expected_rows.pop_front();
        for (int i = 0; i < 12; i++)
          if (got[i] !== want.m[i]) begin
            $display("%0t: m%0d%0d expected %h actual %h", $time, i / 4, i % 4,
                     want.m[i], got[i]);
            n_errors++;
          end
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    unique case ($urandom_range(0, 9))
      0: return lav_pkg::S32_MAX;
      1: return lav_pkg::S32_MIN;
      2: return '0;
      3: return 32'sd1 <<< FB;
      4: return -(32'sd1 <<< FB);
      5: return $urandom_range(0, 7) - 3;
      6, 7: return signed'(32'($urandom_range(0, 1 << 22))) - (1 <<< 21);
      default: return $urandom;
    endcase
  endfunction

  // idle gap; start drops only when the random gap is nonzero
  task automatic pause_random();
    int gap;
    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drive one setup; start stays high so the next beat can follow at once
  task automatic send_camera(camera_t c);
    start <= 1'b1;
    {in_eye_x, in_eye_y, in_eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
    {in_look_x, in_look_y, in_look_z} <= {c.look[0], c.look[1], c.look[2]};
    {in_up_x, in_up_y, in_up_z} <= {c.up[0], c.up[1], c.up[2]};
    do @(posedge clk); while (busy);
    expected_rows.push_back(compute_view(c));
  endtask

  function automatic camera_t make_camera(logic signed [31:0] e [3], logic signed [31:0] l [3],
                                          logic signed [31:0] u [3]);
    camera_t c;
    c.eye = e;
    c.look = l;
    c.up = u;
    return c;
  endfunction

  task automatic test_directed();
    localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
    logic signed [31:0] mx, mn;
    mx = lav_pkg::S32_MAX;
    mn = lav_pkg::S32_MIN;
    send_camera(make_camera('{0, 0, 0}, '{0, 0, -ONE}, '{0, ONE, 0}));
    send_camera(make_camera('{ONE, 2 * ONE, 3 * ONE}, '{0, 0, -ONE}, '{0, ONE, 0}));
    // zero look collapses every axis
    send_camera(make_camera('{ONE, ONE, ONE}, '{0, 0, 0}, '{0, ONE, 0}));
    // up parallel to look
    send_camera(make_camera('{ONE, 0, 0}, '{0, ONE, 0}, '{0, 3 * ONE, 0}));
    send_camera(make_camera('{ONE, 0, 0}, '{ONE, ONE, ONE}, '{0, 0, 0}));
    // translation saturation both ways
    send_camera(make_camera('{mx, mx, mx}, '{ONE, ONE, ONE}, '{0, ONE, 0}));
    send_camera(make_camera('{mn, mn, mn}, '{ONE, ONE, ONE}, '{0, ONE, 0}));
    send_camera(make_camera('{mn, mx, mn}, '{mn, mn, mn}, '{mn, mx, mn}));
    send_camera(make_camera('{mx, mn, mx}, '{mx, mx, mx}, '{mx, mn, 0}));
    send_camera(make_camera('{-1, -1, -1}, '{1, 0, 0}, '{0, 0, 1}));
    send_camera(make_camera('{mn, 0, mx}, '{mn, 1, -1}, '{-1, mn, mx}));
    send_camera(make_camera('{0, mx, 0}, '{-1, -1, -1}, '{mx, mx, mn}));
    send_camera(make_camera('{3, -5, 7}, '{ONE, 0, 0}, '{0, -ONE, 0}));
    repeat (3) send_camera(make_camera('{ONE, -ONE, 0}, '{0, -ONE, ONE}, '{ONE, 0, 0}));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_random(int count);
    camera_t c;
    for (int n = 0; n < count; n++) begin
      foreach (c.eye[i]) begin
        c.eye[i] = rand_word();
        c.look[i] = rand_word();
        c.up[i] = rand_word();
      end
      // sometimes make up parallel to look
      if ($urandom_range(0, 19) == 0) c.up = c.look;
      send_camera(c);
      if ($urandom_range(0, 2) != 0) pause_random();
    end
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_drain();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1600);
    test_drain();
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
